/* rtl/core/hfcra_pkg.sv */
// ----------------------------------------------------------------------------
// hfcra_pkg
// Shared types, constants and helpers for the hex frame range averager.
// ----------------------------------------------------------------------------
package hfcra_pkg;

   // field widths of the channels
   localparam int BYTE_W = 8;
   localparam int DIST_W = 13;
   localparam int GOOD_W = 12;

   // default saturation point of the good frame counter
   localparam int COUNT_MAX_DEF = 4095;

   // frame characters
   localparam logic [7:0] CHAR_START = 8'h7E;
   localparam logic [7:0] CHAR_CR    = 8'd13;
   localparam logic [7:0] CHAR_LF    = 8'd10;

   // frame layout: 16 hex digits, crc covers the first 12 (6 bytes)
   localparam logic [4:0] FRAME_DIGITS = 5'd16;
   localparam logic [4:0] CRC_DIGITS   = 5'd12;

   // crc-16/modbus
   localparam int         CRC_W    = 16;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [3:0]  CRC_BITS = 4'd8;

   // serial divider width and first divisor
   localparam int          DIV_W     = 16;
   localparam logic [15:0] DIVIDE_BY = 16'd10;

   // control state of the top level
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV10,
      ST_DIVC,
      ST_PUSH
   } state_type;

   // crc unit control and status
   typedef struct packed {
      logic             init;
      logic             start;
      logic [BYTE_W-1:0] data;
   } crc_ctl_type;

   typedef struct packed {
      logic            busy;
      logic [CRC_W-1:0] crc;
   } crc_sts_type;

   // divider control and status
   typedef struct packed {
      logic            start;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_ctl_type;

   typedef struct packed {
      logic            busy;
      logic            done;
      logic [DIV_W-1:0] quotient;
   } div_sts_type;

   // ascii hex decode: bit 4 flags a valid digit, bits 3:0 hold its value
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] res;
      res = 5'd0;
      case (c) inside
         [8'h30:8'h39]: res = {1'b1, 4'(c - 8'h30)};
         [8'h61:8'h66]: res = {1'b1, 4'(c - 8'h57)};
         [8'h41:8'h46]: res = {1'b1, 4'(c - 8'h37)};
         default:       res = 5'd0;
      endcase
      return res;
   endfunction

endpackage

/* rtl/core/hfcra_if.sv */
// ----------------------------------------------------------------------------
// hfcra_if
// Valid/ready channels for received bytes and for averaged readings.
// ----------------------------------------------------------------------------
interface hfcra_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       byte_present;
   logic       window_end;

   modport source (output valid, rx_byte, byte_present, window_end, input ready);
   modport sink   (input valid, rx_byte, byte_present, window_end, output ready);
endinterface

interface hfcra_rsp_if;
   logic        valid;
   logic        ready;
   logic        reading_valid;
   logic [12:0] range_avg;
   logic [11:0] good_frames;

   modport source (output valid, reading_valid, range_avg, good_frames, input ready);
   modport sink   (input valid, reading_valid, range_avg, good_frames, output ready);
endinterface

/* rtl/core/hfcra_crc.sv */
// ----------------------------------------------------------------------------
// hfcra_crc
// Bit-serial CRC-16/MODBUS: one byte is folded in, then one bit per cycle.
// ----------------------------------------------------------------------------
module hfcra_crc
   import hfcra_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  crc_ctl_type ctl,
   output crc_sts_type sts
);

   logic [CRC_W-1:0] crc_ff, crc_in;
   logic [3:0]       cnt_ff, cnt_in;

   // next crc: init, byte load or one reflected shift step
   always_comb begin
      crc_in = crc_ff;
      cnt_in = cnt_ff;
      if (ctl.init) begin
         crc_in = CRC_INIT;
         cnt_in = 4'd0;
      end else if (ctl.start) begin
         crc_in = crc_ff ^ {{(CRC_W-BYTE_W){1'b0}}, ctl.data};
         cnt_in = CRC_BITS;
      end else if (cnt_ff != 4'd0) begin
         crc_in = crc_ff[0] ? ((crc_ff >> 1) ^ CRC_POLY) : (crc_ff >> 1);
         cnt_in = cnt_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CRC_INIT;
         cnt_ff <= 4'd0;
      end else begin
         crc_ff <= crc_in;
         cnt_ff <= cnt_in;
      end
   end

   assign sts.busy = (cnt_ff != 4'd0);
   assign sts.crc  = crc_ff;

   // a new byte only lands once the previous one is fully shifted
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> (cnt_ff == 4'd0))
      else $error("crc byte loaded while shifting");

   // a loaded byte sets the bit counter to the byte's bit count
   a_busy_after_load: assert property (@(posedge clock) disable iff (reset)
      (ctl.start && !ctl.init) |=> (cnt_ff == CRC_BITS))
      else $error("crc bit counter not loaded");

   a_idle_after_init: assert property (@(posedge clock) disable iff (reset)
      ctl.init |=> (crc_ff == CRC_INIT && cnt_ff == 4'd0))
      else $error("crc init failed");

endmodule

/* rtl/core/hfcra_div.sv */
// ----------------------------------------------------------------------------
// hfcra_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hfcra_div
   import hfcra_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_ctl_type ctl,
   output div_sts_type sts
);

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [DIV_W:0]   shifted;
   logic [DIV_W:0]   diff;

   // trial subtract of the divisor from the shifted remainder
   assign shifted = {rem_ff, quo_ff[DIV_W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         rem_in = '0;
         quo_in = ctl.dividend;
         dvs_in = ctl.divisor;
         cnt_in = CNT_W'(DIV_W);
      end else if (cnt_ff != '0) begin
         if (!diff[DIV_W]) begin
            rem_in = diff[DIV_W-1:0];
         end else begin
            rem_in = shifted[DIV_W-1:0];
         end
         quo_in  = {quo_ff[DIV_W-2:0], ~diff[DIV_W]};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign sts.busy     = (cnt_ff != '0);
   assign sts.done     = done_ff;
   assign sts.quotient = quo_ff;

   // remainder stays below the divisor between steps
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != '0 && cnt_ff != CNT_W'(DIV_W)) |-> (rem_ff < dvs_ff))
      else $error("divider remainder out of range");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (cnt_ff == '0))
      else $error("divider done while still stepping");

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> (cnt_ff == '0))
      else $error("divider restarted while busy");

endmodule

/* rtl/core/hex_frame_crc16_range_averager.sv */
// ----------------------------------------------------------------------------
// hex_frame_crc16_range_averager
// Parses '~' + 16 hex digits + CR LF range frames, checks CRC-16/MODBUS and
// reports the windowed average distance and good frame count.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                     | handshake
//  req_ch  | in  | rx_byte, byte_present, window_end           | valid/ready
//  rsp_ch  | out | reading_valid, range_avg, good_frames       | valid/ready
//
//  Each completed crc byte (every second of the first twelve digits) is
//  shifted through the bit-serial crc unit, which holds off new bytes while
//  busy. A window end with good frames runs two passes of the serial divider
//  (sum by 10, then by the frame count) before the hand-off; a window end
//  with no good frame goes straight to the hand-off.
//  Reset is synchronous and clears the parser flags and index, sum and count.
//  The push state holds off new transactions until the output register is
//  free; once it is loaded, bytes keep flowing while the reading waits.
// ----------------------------------------------------------------------------
module hex_frame_crc16_range_averager
   import hfcra_pkg::*;
#(
   parameter int COUNT_MAX = COUNT_MAX_DEF
)
(
   input logic         clock,
   input logic         reset,
   hfcra_req_if.sink   req_ch,
   hfcra_rsp_if.source rsp_ch
);

   localparam int CNT_W = $clog2(COUNT_MAX + 1);

   state_type state_ff, state_in;

   // frame parser state
   logic              capturing_ff, capturing_in;
   logic [4:0]        idx_ff, idx_in;
   logic              derr_ff, derr_in;
   logic              cr_ff, cr_in;
   logic [3:0]        hi_nib_ff, hi_nib_in;
   logic [31:0]       tail_ff, tail_in;

   // window accumulators
   logic [15:0]       sum_ff, sum_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  win_count_ff, win_count_in;
   logic [DIST_W-1:0] avg_ff, avg_in;

   // output register
   logic              rsp_valid_ff;
   logic              rsp_reading_ff;
   logic [DIST_W-1:0] rsp_dist_ff;
   logic [GOOD_W-1:0] rsp_good_ff;
   logic              rsp_load;

   crc_ctl_type       crc_ctl;
   crc_sts_type       crc_sts;
   div_ctl_type       div_ctl;
   div_sts_type       div_sts;

   logic              req_fire;
   logic [4:0]        hex;
   logic              crc_match;
   logic              frame_good;
   logic [15:0]       sum_next;
   logic [CNT_W-1:0]  count_next;

   hfcra_crc u_crc (
      .clock (clock),
      .reset (reset),
      .ctl   (crc_ctl),
      .sts   (crc_sts)
   );

   hfcra_div u_div (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .sts   (div_sts)
   );

   assign req_ch.ready = (state_ff == ST_IDLE) && !crc_sts.busy;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign hex          = hex_decode(req_ch.rx_byte);

   // crc arrives low byte first in the last four digits
   assign crc_match  = (crc_sts.crc == {tail_ff[7:0], tail_ff[15:8]});
   assign frame_good = req_fire && req_ch.byte_present && capturing_ff &&
                       (idx_ff == FRAME_DIGITS + 5'd1) && (req_ch.rx_byte == CHAR_LF) &&
                       !derr_ff && cr_ff && crc_match;
   assign sum_next   = frame_good ? (sum_ff + tail_ff[31:16]) : sum_ff;
   assign count_next = (frame_good && (count_ff < CNT_W'(COUNT_MAX))) ?
                       (count_ff + 1'b1) : count_ff;

   // frame parser, one character per transaction
   always_comb begin
      capturing_in = capturing_ff;
      idx_in       = idx_ff;
      derr_in      = derr_ff;
      cr_in        = cr_ff;
      hi_nib_in    = hi_nib_ff;
      tail_in      = tail_ff;
      sum_in       = sum_next;
      count_in     = count_next;
      crc_ctl      = '0;
      if (req_fire && req_ch.byte_present) begin
         if (!capturing_ff) begin
            if (req_ch.rx_byte == CHAR_START) begin
               capturing_in = 1'b1;
               idx_in       = 5'd0;
               derr_in      = 1'b0;
               cr_in        = 1'b0;
               crc_ctl.init = 1'b1;
            end
         end else if (idx_ff < FRAME_DIGITS) begin
            if (!hex[4]) begin
               derr_in = 1'b1;
            end else begin
               tail_in = {tail_ff[27:0], hex[3:0]};
            end
            idx_in = idx_ff + 5'd1;
            // pair digits into bytes for the crc
            if (idx_ff < CRC_DIGITS) begin
               if (!idx_ff[0]) begin
                  hi_nib_in = hex[3:0];
               end else begin
                  crc_ctl.start = 1'b1;
                  crc_ctl.data  = {hi_nib_ff, hex[3:0]};
               end
            end
         end else if (idx_ff == FRAME_DIGITS) begin
            cr_in  = (req_ch.rx_byte == CHAR_CR);
            idx_in = idx_ff + 5'd1;
         end else begin
            capturing_in = 1'b0;
            idx_in       = 5'd0;
         end
      end
      // window end clears the parser and the accumulators after the byte is taken
      if (req_fire && req_ch.window_end) begin
         capturing_in = 1'b0;
         idx_in       = 5'd0;
         derr_in      = 1'b0;
         cr_in        = 1'b0;
         sum_in       = '0;
         count_in     = '0;
      end
   end

   // window end sequencer: two divider passes when there are good frames, then hand-off
   always_comb begin
      state_in     = state_ff;
      win_count_in = win_count_ff;
      avg_in       = avg_ff;
      div_ctl      = '0;
      rsp_load     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_ch.window_end) begin
               win_count_in = count_next;
               if (count_next != '0) begin
                  div_ctl.start    = 1'b1;
                  div_ctl.dividend = sum_next;
                  div_ctl.divisor  = DIVIDE_BY;
                  state_in         = ST_DIV10;
               end else begin
                  avg_in   = '0;
                  state_in = ST_PUSH;
               end
            end
         end
         ST_DIV10: begin
            if (div_sts.done) begin
               div_ctl.start    = 1'b1;
               div_ctl.dividend = div_sts.quotient;
               div_ctl.divisor  = DIV_W'(win_count_ff);
               state_in         = ST_DIVC;
            end
         end
         ST_DIVC: begin
            if (div_sts.done) begin
               avg_in   = div_sts.quotient[DIST_W-1:0];
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         capturing_ff <= 1'b0;
         idx_ff       <= 5'd0;
         derr_ff      <= 1'b0;
         cr_ff        <= 1'b0;
         sum_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         capturing_ff <= capturing_in;
         idx_ff       <= idx_in;
         derr_ff      <= derr_in;
         cr_ff        <= cr_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      hi_nib_ff    <= hi_nib_in;
      tail_ff      <= tail_in;
      win_count_ff <= win_count_in;
      avg_ff       <= avg_in;
      if (rsp_load) begin
         rsp_reading_ff <= (win_count_ff != '0);
         rsp_dist_ff    <= avg_ff;
         rsp_good_ff    <= GOOD_W'(win_count_ff);
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.reading_valid = rsp_reading_ff;
   assign rsp_ch.range_avg     = rsp_dist_ff;
   assign rsp_ch.good_frames   = rsp_good_ff;

   // a window end always leaves the accumulators and parser cleared
   a_window_clears: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_ch.window_end) |=> (count_ff == '0 && sum_ff == '0 && !capturing_ff))
      else $error("window end did not clear state");

   // parser index only runs while capturing
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      capturing_ff ? (idx_ff <= FRAME_DIGITS + 5'd1) : (idx_ff == 5'd0))
      else $error("frame index out of range");

   // an invalid reading carries zero payload
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_reading_ff) |-> (rsp_dist_ff == '0 && rsp_good_ff == '0))
      else $error("invalid reading with nonzero payload");

   // the crc unit never receives a byte while a transaction is blocked on it
   a_crc_quiet: assert property (@(posedge clock) disable iff (reset)
      crc_sts.busy |-> (!req_ch.ready && !crc_ctl.start))
      else $error("byte taken while crc busy");

endmodule
